>>> rtl/scpa_pkg.sv
package scpa_pkg;

    // Default sizes of the slot stores
    localparam int NUM_COLUMNS_DEF      = 1024;
    localparam int SLOTS_PER_COLUMN_DEF = 32;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 10;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 2;
    localparam int SLOTO_W  = 5;
    localparam int CNT_W    = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACCUMULATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd3;

    // Q31.32 saturation limits
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] add_value;
        logic                    end_of_element;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOTO_W-1:0]      slot_found;
        logic signed [VAL_W-1:0] entry_value;
        logic [CNT_W-1:0]        element_count;
        logic [CNT_W-1:0]        nonzero_total;
    } out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FILLC,
        S_FILLR,
        S_SEARCH,
        S_EXEC,
        S_APPEND2,
        S_DONE
    } state_t;

endpackage

>>> rtl/sparse_column_pattern_assembler.sv
// Sparse column pattern assembler.
// Input channel in_valid/in_ready/in_data carries one command beat: insert a
// symmetric pattern pair, accumulate a Q31.32 term into an entry, or read it.
// Output channel out_valid/out_ready/out_data returns one result beat for
// every command: status, slot, stored value and the two counters.
// One command at a time: an accepted command passes through the two fill lookups,
// the slot search over the used slots of the addressed column (fill, at most
// SLOTS_PER_COLUMN), the execute step and the result step; an off-diagonal
// insert adds a mirror-write step but never runs on a full column. The next
// command can be accepted in the cycle after the result is loaded.
// The slot search reads one row slot per cycle from the single read port of
// the row-slot memory.
// After reset the column fill memory is swept to zero, one column a cycle,
// over all NUM_COLUMNS columns; in_ready stays low during the sweep. Counters
// clear at reset.
// A finished result sits in the output register; the next command is
// accepted while it waits. If the receiver stalls, the following result
// holds inside the block, and no new command is accepted until it moves.
module sparse_column_pattern_assembler #(
    parameter int NUM_COLUMNS      = scpa_pkg::NUM_COLUMNS_DEF,
    parameter int SLOTS_PER_COLUMN = scpa_pkg::SLOTS_PER_COLUMN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  scpa_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output scpa_pkg::out_t out_data
);

    localparam int COL_W      = $clog2(NUM_COLUMNS);
    localparam int SLOT_W     = (SLOTS_PER_COLUMN > 1) ? $clog2(SLOTS_PER_COLUMN) : 1;
    localparam int FILL_W     = $clog2(SLOTS_PER_COLUMN + 1);
    localparam int COL_DEPTH  = 1 << COL_W;
    localparam int SLOT_DEPTH = COL_DEPTH << SLOT_W;
    localparam int RANGE_W    = COL_W + scpa_pkg::IDX_W + 1;
    localparam int ADDR_W     = COL_W + SLOT_W;
    localparam logic [COL_W-1:0]  CLR_LAST = COL_W'(NUM_COLUMNS - 1);
    localparam logic [FILL_W-1:0] FILL_CAP = FILL_W'(SLOTS_PER_COLUMN);

    // control state
    scpa_pkg::state_t state_reg, state_next;
    logic [COL_W-1:0] clr_reg, clr_next;
    logic pend_reg, pend_next;
    logic out_valid_reg, out_valid_next;
    logic [scpa_pkg::CNT_W-1:0] elem_cnt_reg, elem_cnt_next;
    logic [scpa_pkg::CNT_W-1:0] total_reg, total_next;

    // payload
    scpa_pkg::in_t item_reg, item_next;
    logic [COL_W-1:0] col_addr_reg, col_addr_next;
    logic [COL_W-1:0] row_addr_reg, row_addr_next;
    logic in_range_reg, in_range_next;
    logic [FILL_W-1:0] fill_c_reg, fill_c_next;
    logic [FILL_W-1:0] fill_r_reg, fill_r_next;
    logic [FILL_W-1:0] scan_k_reg, scan_k_next;
    logic [SLOT_W-1:0] pend_k_reg, pend_k_next;
    logic found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic signed [scpa_pkg::VAL_W-1:0] value_reg, value_next;
    logic [scpa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [scpa_pkg::CNT_W-1:0] count_out_reg, count_out_next;
    scpa_pkg::out_t out_data_reg, out_data_next;

    // memory ports
    logic fill_we;
    logic [COL_W-1:0] fill_waddr, fill_raddr;
    logic [FILL_W-1:0] fill_wdata, fill_rdata;
    logic slot_we;
    logic [ADDR_W-1:0] slot_waddr, slot_raddr;
    logic [scpa_pkg::IDX_W-1:0] row_wdata, row_rdata;
    logic signed [scpa_pkg::VAL_W-1:0] val_wdata, val_rdata;

    logic accept;
    logic issue;
    logic hit;
    logic signed [scpa_pkg::VAL_W-1:0] sum;
    logic ovf;
    logic signed [scpa_pkg::VAL_W-1:0] sat_sum;
    logic [scpa_pkg::CNT_W-1:0] cnt_after;

    scpa_ram #(
        .WIDTH (FILL_W),
        .DEPTH (COL_DEPTH)
    ) u_fill_ram (
        .clk     (clk),
        .wr_en   (fill_we),
        .wr_addr (fill_waddr),
        .wr_data (fill_wdata),
        .rd_addr (fill_raddr),
        .rd_data (fill_rdata)
    );

    scpa_ram #(
        .WIDTH (scpa_pkg::IDX_W),
        .DEPTH (SLOT_DEPTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (row_wdata),
        .rd_addr (slot_raddr),
        .rd_data (row_rdata)
    );

    scpa_ram #(
        .WIDTH (scpa_pkg::VAL_W),
        .DEPTH (SLOT_DEPTH)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (val_wdata),
        .rd_addr (slot_raddr),
        .rd_data (val_rdata)
    );

    assign in_ready  = (state_reg == scpa_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign issue = (scan_k_reg < fill_c_reg);
    assign hit   = pend_reg && (row_rdata == item_reg.row_index);

    // saturating Q31.32 add
    assign sum = value_reg + item_reg.add_value;
    assign ovf = (value_reg[scpa_pkg::VAL_W-1] == item_reg.add_value[scpa_pkg::VAL_W-1])
              && (sum[scpa_pkg::VAL_W-1] != value_reg[scpa_pkg::VAL_W-1]);
    assign sat_sum = ovf ? (value_reg[scpa_pkg::VAL_W-1] ? scpa_pkg::VAL_MIN
                                                         : scpa_pkg::VAL_MAX)
                         : sum;

    assign cnt_after = (elem_cnt_reg == '1) ? elem_cnt_reg
                                            : elem_cnt_reg + scpa_pkg::CNT_W'(1);

    // one search read per cycle, row and value side by side
    assign slot_raddr = {col_addr_reg, scan_k_reg[SLOT_W-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        elem_cnt_next  = elem_cnt_reg;
        total_next     = total_reg;
        item_next      = item_reg;
        col_addr_next  = col_addr_reg;
        row_addr_next  = row_addr_reg;
        in_range_next  = in_range_reg;
        fill_c_next    = fill_c_reg;
        fill_r_next    = fill_r_reg;
        scan_k_next    = scan_k_reg;
        pend_k_next    = pend_k_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        count_out_next = count_out_reg;
        out_data_next  = out_data_reg;

        fill_we    = 1'b0;
        fill_waddr = col_addr_reg;
        fill_wdata = fill_c_reg + FILL_W'(1);
        fill_raddr = row_addr_reg;
        slot_we    = 1'b0;
        slot_waddr = {col_addr_reg, slot_reg};
        row_wdata  = item_reg.row_index;
        val_wdata  = '0;

        // drain the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            scpa_pkg::S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = scpa_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + COL_W'(1);
                end
            end

            scpa_pkg::S_IDLE:
            begin
                fill_raddr = COL_W'(in_data.col_index);
                if (accept)
                begin
                    item_next     = in_data;
                    col_addr_next = COL_W'(in_data.col_index);
                    row_addr_next = COL_W'(in_data.row_index);
                    in_range_next = (RANGE_W'(in_data.row_index) < RANGE_W'(NUM_COLUMNS))
                                 && (RANGE_W'(in_data.col_index) < RANGE_W'(NUM_COLUMNS));
                    state_next    = scpa_pkg::S_FILLC;
                end
            end

            scpa_pkg::S_FILLC:
            begin
                // an out-of-range row or column searches nothing
                fill_c_next = in_range_reg ? fill_rdata : '0;
                scan_k_next = '0;
                pend_next   = 1'b0;
                state_next  = scpa_pkg::S_FILLR;
            end

            scpa_pkg::S_FILLR:
            begin
                fill_r_next = fill_rdata;
                state_next  = scpa_pkg::S_SEARCH;
            end

            scpa_pkg::S_SEARCH:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    slot_next  = pend_k_reg;
                    value_next = val_rdata;
                    pend_next  = 1'b0;
                    state_next = scpa_pkg::S_EXEC;
                end
                else if (!issue)
                begin
                    found_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = scpa_pkg::S_EXEC;
                end
                else
                begin
                    pend_next   = 1'b1;
                    pend_k_next = scan_k_reg[SLOT_W-1:0];
                    scan_k_next = scan_k_reg + FILL_W'(1);
                end
            end

            scpa_pkg::S_EXEC:
            begin
                count_out_next = elem_cnt_reg;
                state_next     = scpa_pkg::S_DONE;
                unique case (item_reg.cmd)
                    scpa_pkg::CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = scpa_pkg::ST_PRESENT;
                        end
                        else if (!in_range_reg || (fill_c_reg >= FILL_CAP)
                                 || ((item_reg.row_index != item_reg.col_index)
                                     && (fill_r_reg >= FILL_CAP)))
                        begin
                            status_next = scpa_pkg::ST_FULL;
                            slot_next   = '0;
                            value_next  = '0;
                        end
                        else
                        begin
                            status_next = scpa_pkg::ST_OK;
                            slot_next   = fill_c_reg[SLOT_W-1:0];
                            value_next  = '0;
                            slot_we     = 1'b1;
                            slot_waddr  = {col_addr_reg, fill_c_reg[SLOT_W-1:0]};
                            fill_we     = 1'b1;
                            total_next  = (total_reg == '1) ? total_reg
                                                            : total_reg + scpa_pkg::CNT_W'(1);
                            if (item_reg.row_index != item_reg.col_index)
                            begin
                                state_next = scpa_pkg::S_APPEND2;
                            end
                        end
                    end

                    scpa_pkg::CMD_ACCUMULATE:
                    begin
                        if (found_reg)
                        begin
                            status_next    = scpa_pkg::ST_OK;
                            value_next     = sat_sum;
                            slot_we        = 1'b1;
                            val_wdata      = sat_sum;
                            count_out_next = cnt_after;
                            elem_cnt_next  = item_reg.end_of_element ? '0 : cnt_after;
                        end
                        else
                        begin
                            status_next = scpa_pkg::ST_ABSENT;
                            slot_next   = '0;
                            value_next  = '0;
                            if (item_reg.end_of_element)
                            begin
                                elem_cnt_next = '0;
                            end
                        end
                    end

                    default:
                    begin
                        if (found_reg)
                        begin
                            status_next = scpa_pkg::ST_OK;
                        end
                        else
                        begin
                            status_next = scpa_pkg::ST_ABSENT;
                            slot_next   = '0;
                            value_next  = '0;
                        end
                    end
                endcase
            end

            scpa_pkg::S_APPEND2:
            begin
                // mirrored entry in the row's column
                slot_we    = 1'b1;
                slot_waddr = {row_addr_reg, fill_r_reg[SLOT_W-1:0]};
                row_wdata  = item_reg.col_index;
                fill_we    = 1'b1;
                fill_waddr = row_addr_reg;
                fill_wdata = fill_r_reg + FILL_W'(1);
                total_next = (total_reg == '1) ? total_reg
                                               : total_reg + scpa_pkg::CNT_W'(1);
                state_next = scpa_pkg::S_DONE;
            end

            scpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.slot_found    = scpa_pkg::SLOTO_W'(slot_reg);
                    out_data_next.entry_value   = value_reg;
                    out_data_next.element_count = count_out_reg;
                    out_data_next.nonzero_total = total_reg;
                    state_next                  = scpa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = scpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scpa_pkg::S_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            elem_cnt_reg  <= '0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            elem_cnt_reg  <= elem_cnt_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        col_addr_reg  <= col_addr_next;
        row_addr_reg  <= row_addr_next;
        in_range_reg  <= in_range_next;
        fill_c_reg    <= fill_c_next;
        fill_r_reg    <= fill_r_next;
        scan_k_reg    <= scan_k_next;
        pend_k_reg    <= pend_k_next;
        found_reg     <= found_next;
        slot_reg      <= slot_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        count_out_reg <= count_out_next;
        out_data_reg  <= out_data_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == scpa_pkg::S_FILLC))
        else $error("accepted command did not start the fill lookup");

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scpa_pkg::S_SEARCH) |-> (fill_c_reg <= FILL_CAP))
        else $error("column fill beyond capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scpa_pkg::S_SEARCH) |-> (scan_k_reg <= fill_c_reg))
        else $error("slot search ran past the column fill");

    a_hit_below_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == scpa_pkg::S_EXEC) && found_reg)
        |-> (FILL_W'(slot_reg) < fill_c_reg))
        else $error("found slot not below column fill");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scpa_pkg::S_CLEAR) |=> !$past(accept))
        else $error("command accepted during fill sweep");

endmodule

>>> rtl/scpa_ram.sv
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
